// File: hw/rtl/wol_pkg.sv
// ----------------------------------------------------------------------------
// wol_pkg
// Shared types and constants of the wavetable oscillator with interpolation.
// ----------------------------------------------------------------------------
package wol_pkg;

    // table and number formats
    localparam int TABLE_DEPTH  = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int PHASE_WIDTH  = 32;
    localparam int IDX_W        = 11;
    localparam int FRAC_W       = 16;
    localparam int WAVE_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // queue depths between the parts
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 2;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK_BASE = 2'd0,
        OP_TICK_STEP = 2'd1,
        OP_WRITE     = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    // waveform codes, the unused ones play sine
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_USER     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC = 2'd1;

    // command from front to back: a tick (entry index and fraction) or a table write
    typedef struct packed {
        logic                    is_write;
        logic [IDX_W-1:0]        addr;
        logic [SAMPLE_WIDTH-1:0] data;
    } t_cmd;

endpackage

// File: hw/rtl/wavetable_oscillator_lerp.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_lerp
// Wavetable oscillator with linear interpolation between adjacent entries.
// ----------------------------------------------------------------------------
//  channel    | handshake                  | moves
//  -----------+----------------------------+----------------------------------
//  input      | push / full                | operation, increment, table item
//  result     | empty / pop                | sample
//  config     | i_cfg_valid / o_cfg_ready  | register index and write data
//
//  One item a cycle in steady state, while the result queue has room.
//  The front steps the phase on accept; the back reads both table entries in
//  the same cycle from two-port tables, then interpolates over two more stages.
//  Reset clears phase, waveform and base step; the user table is not cleared.
//  A full result queue holds the back pipe; the 4-slot command queue then
//  fills and raises full.
// ----------------------------------------------------------------------------
module wavetable_oscillator_lerp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [1:0]                              i_operation,
    input  logic signed [wol_pkg::PHASE_WIDTH-1:0]  i_increment,
    input  logic [wol_pkg::IDX_W-1:0]               i_table_index,
    input  logic signed [wol_pkg::SAMPLE_WIDTH-1:0] i_table_value,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [wol_pkg::SAMPLE_WIDTH-1:0] o_sample,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [wol_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [wol_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import wol_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic [WAVE_W-1:0]             r_waveform;
    logic signed [PHASE_WIDTH-1:0] r_base_inc;
    logic                          accept;
    logic                          cmd_push;
    t_cmd                          cmd_in;
    logic [CMD_W-1:0]              cmd_bits;
    t_cmd                          cmd_head;
    logic                          cmd_full;
    logic                          cmd_empty;
    logic                          cmd_pop;
    logic                          res_push;
    logic                          res_full;
    logic signed [SAMPLE_WIDTH-1:0] res_sample;
    logic [SAMPLE_WIDTH-1:0]       res_bits;

    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;
    assign accept      = push && !cmd_full;
    assign cmd_head    = t_cmd'(cmd_bits);
    assign o_sample    = signed'(res_bits);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= WAVE_SINE;
            r_base_inc <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WAVEFORM: r_waveform <= i_cfg_data[WAVE_W-1:0];
                CFG_BASE_INC: r_base_inc <= signed'(i_cfg_data[PHASE_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    wol_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_operation      (i_operation),
        .i_increment      (i_increment),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .i_base_increment (r_base_inc),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    wol_queue #(
        .DEPTH (CMD_QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (cmd_empty)
    );

    wol_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_waveform   (r_waveform),
        .i_cmd_valid  (!cmd_empty),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res_sample (res_sample)
    );

    wol_queue #(
        .DEPTH (RES_QUEUE_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_sample),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

endmodule

// File: hw/rtl/wol_queue.sv
// ----------------------------------------------------------------------------
// wol_queue
// Small first-in first-out queue of register slots with count.
// ----------------------------------------------------------------------------
module wol_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // count never runs past the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/wol_front.sv
// ----------------------------------------------------------------------------
// wol_front
// Accepts items, drops dead ones, steps the phase and turns ticks into reads.
// ----------------------------------------------------------------------------
module wol_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [1:0]                         i_operation,
    input  logic signed [wol_pkg::PHASE_WIDTH-1:0]  i_increment,
    input  logic [wol_pkg::IDX_W-1:0]          i_table_index,
    input  logic signed [wol_pkg::SAMPLE_WIDTH-1:0] i_table_value,
    input  logic signed [wol_pkg::PHASE_WIDTH-1:0]  i_base_increment,
    output logic                               o_cmd_push,
    output wol_pkg::t_cmd                      o_cmd
);
    import wol_pkg::*;

    localparam int PROD_W = PHASE_WIDTH + 1 + IDX_W;

    logic [PHASE_WIDTH-1:0] r_acc;
    logic [PHASE_WIDTH-1:0] n_acc;
    t_op                    op;
    logic                   is_tick;
    logic                   is_write;
    logic [PHASE_WIDTH:0]   v;
    logic [PROD_W-1:0]      prod;
    logic [PHASE_WIDTH-1:0] step;

    // classify the item
    always_comb begin
        op       = t_op'(i_operation);
        is_tick  = (op inside {OP_TICK_BASE, OP_TICK_STEP});
        is_write = (op == OP_WRITE) && (i_table_index <= IDX_W'(TABLE_DEPTH));
    end

    // backwards read point: v = a full phase turn minus phase, scaled by depth minus one
    always_comb begin
        v    = {1'b1, {PHASE_WIDTH{1'b0}}} - {1'b0, r_acc};
        prod = PROD_W'(v) * PROD_W'(TABLE_DEPTH - 1);
        step = (op == OP_TICK_BASE) ? i_base_increment : i_increment;
        n_acc = r_acc + step;
    end

    // command into the queue
    always_comb begin
        o_cmd_push = i_accept && (is_tick || is_write);
        o_cmd.is_write = !is_tick;
        if (is_tick) begin
            o_cmd.addr = prod[PHASE_WIDTH +: IDX_W];
            o_cmd.data = prod[PHASE_WIDTH-FRAC_W +: FRAC_W];
        end else begin
            o_cmd.addr = i_table_index;
            o_cmd.data = i_table_value;
        end
    end

    // phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept && is_tick) begin
            r_acc <= n_acc;
        end
    end

    // phase moves only on an accepted tick
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && is_tick) |=> $stable(r_acc))
        else $error("phase moved without a tick");

endmodule

// File: hw/rtl/wol_back.sv
// ----------------------------------------------------------------------------
// wol_back
// Table reads, interpolation and saturation in a stalling three-stage pipe.
// ----------------------------------------------------------------------------
module wol_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [wol_pkg::WAVE_W-1:0]         i_waveform,
    input  logic                               i_cmd_valid,
    input  wol_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    input  logic                               i_res_full,
    output logic                               o_res_push,
    output logic signed [wol_pkg::SAMPLE_WIDTH-1:0] o_res_sample
);
    import wol_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int FULL = 2 ** (SW - 1);
    localparam int SMAX = FULL - 1;
    localparam int SMIN = -FULL;
    localparam int DW   = SW + 1;
    localparam int PW   = DW + FRAC_W + 1;
    localparam int YW   = PW - FRAC_W + 1;
    localparam logic [63:0] QONE = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HORNER_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic [SW-1:0] t_rom [0:TABLE_DEPTH];

    // sine entry: quarter-wave fold, Horner series to x^11, rounded to sample width
    function automatic logic [SW-1:0] sine_entry(input int unsigned i);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  q;
        a = ((64'(i) << 32) / TABLE_DEPTH) & 64'hFFFF_FFFF;
        q = a[31:30];
        r = a & (QONE - 64'd1);
        if (q[0]) begin
            r = QONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        h  = QONE;
        for (int k = 0; k < 5; k++) begin
            h = QONE - (((x2 * h) >> 30) / HORNER_DIV[k]);
        end
        s   = (x * h) >> 30;
        mag = ((s << (SW - 1)) + (QONE >> 1)) >> 30;
        if (q[1]) begin
            return SW'(64'd0 - mag);
        end
        return (mag > 64'(SMAX)) ? SW'(SMAX) : SW'(mag);
    endfunction

    function automatic t_rom gen_sine_rom();
        t_rom rom;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = gen_sine_rom();

    // triangle, square and saw straight from the entry index
    function automatic logic signed [SW-1:0] shape_entry(
        input logic [WAVE_W-1:0] wave,
        input logic [IDX_W-1:0]  idx
    );
        logic [IDX_W-1:0]  j;
        logic [31:0]       num;
        logic signed [31:0] val;
        j   = (idx == IDX_W'(TABLE_DEPTH)) ? '0 : idx;
        val = '0;
        case (wave)
            WAVE_TRIANGLE: begin
                num = 32'(j) * 32'(2 * FULL) + 32'(TABLE_DEPTH / 2);
                val = signed'(num / TABLE_DEPTH);
                if (32'(j) * 32'd2 >= 32'(TABLE_DEPTH)) begin
                    val = 32'(FULL) - val;
                end
            end
            WAVE_SQUARE: begin
                if (idx == '0 || idx == IDX_W'(TABLE_DEPTH)) begin
                    val = '0;
                end else if (idx <= IDX_W'(TABLE_DEPTH / 2)) begin
                    val = 32'(SMAX);
                end else begin
                    val = 32'(SMIN);
                end
            end
            default: begin
                num = 32'(j) * 32'(FULL) + 32'(TABLE_DEPTH / 2);
                val = 32'(FULL) - signed'(num / TABLE_DEPTH);
            end
        endcase
        if (val > 32'sd0 + SMAX) begin
            return SW'(SMAX);
        end
        return SW'(val);
    endfunction

    logic                 en;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;
    logic signed [SW-1:0] r_user [0:TABLE_DEPTH];

    // stage 1: table reads
    logic                 r1_v;
    logic [SW-1:0]        r1_rom_a;
    logic [SW-1:0]        r1_rom_b;
    logic signed [SW-1:0] r1_usr_a;
    logic signed [SW-1:0] r1_usr_b;
    logic signed [SW-1:0] r1_shp_a;
    logic signed [SW-1:0] r1_shp_b;
    logic [FRAC_W-1:0]    r1_frac;
    // stage 2: chosen entries and difference
    logic                 r2_v;
    logic signed [SW-1:0] r2_a;
    logic signed [DW-1:0] r2_diff;
    logic [FRAC_W-1:0]    r2_frac;
    logic signed [SW-1:0] sel_a;
    logic signed [SW-1:0] sel_b;
    // stage 3: product
    logic                 r3_v;
    logic signed [SW-1:0] r3_a;
    logic signed [PW-1:0] r3_prod;
    logic signed [PW-1:0] rnd;
    logic signed [YW-1:0] y;

    // the pipe moves unless a finished sample has nowhere to go
    assign en        = !(r3_v && i_res_full);
    assign o_cmd_pop = en && i_cmd_valid;
    assign idx_a     = i_cmd.addr;
    assign idx_b     = i_cmd.addr + 1'b1;

    // user table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.is_write) begin
            r_user[i_cmd.addr] <= i_cmd.data;
        end
        if (en) begin
            r1_usr_a <= r_user[idx_a];
            r1_usr_b <= r_user[idx_b];
        end
    end

    // sine rom and shape reads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rom_a <= SINE_ROM[idx_a];
            r1_rom_b <= SINE_ROM[idx_b];
            r1_shp_a <= shape_entry(i_waveform, idx_a);
            r1_shp_b <= shape_entry(i_waveform, idx_b);
            r1_frac  <= i_cmd.data;
        end
    end

    // waveform selection
    always_comb begin
        case (i_waveform)
            WAVE_USER: begin
                sel_a = r1_usr_a;
                sel_b = r1_usr_b;
            end
            WAVE_TRIANGLE, WAVE_SQUARE, WAVE_SAW: begin
                sel_a = r1_shp_a;
                sel_b = r1_shp_b;
            end
            default: begin
                sel_a = signed'(r1_rom_a);
                sel_b = signed'(r1_rom_b);
            end
        endcase
    end

    // stage 2 and 3 payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a    <= sel_a;
            r2_diff <= DW'(sel_b) - DW'(sel_a);
            r2_frac <= r1_frac;
            r3_a    <= r2_a;
            r3_prod <= PW'(r2_diff) * signed'(PW'(r2_frac));
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= o_cmd_pop && !i_cmd.is_write;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // round half up, add and saturate
    always_comb begin
        rnd = r3_prod + PW'(32768);
        y   = YW'(r3_a) + YW'(rnd >>> FRAC_W);
        if (y > YW'(SMAX)) begin
            o_res_sample = SW'(SMAX);
        end else if (y < YW'(SMIN)) begin
            o_res_sample = SW'(SMIN);
        end else begin
            o_res_sample = SW'(y);
        end
        o_res_push = r3_v && !i_res_full;
    end

    // a stalled sample keeps its product
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && !en |=> r3_v && $stable(r3_prod) && $stable(r3_a))
        else $error("stalled sample changed");

    // table writes make no sample
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop && i_cmd.is_write |=> !r1_v)
        else $error("table write produced a sample");

endmodule

// File: tb/tb_wavetable_oscillator_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator_lerp
// Self-checking bench for the interpolating wavetable oscillator. A directed
// table covers reset state, extreme steps, every waveform, unused codes and
// table writes out of range; randomised phases follow, each with its own
// waveform and base step. Both queue sides idle at random. Every sample is
// matched to a set row value or a predictor of phase, registers, user table.
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator_lerp;
    import wol_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_DIRECTED    = 33;

    // codes the package leaves unnamed
    localparam logic [WAVE_W-1:0]    WAVE_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;

    // number formats of the predictor
    localparam logic [PHASE_WIDTH-1:0] STEP_MAX   = 32'h7FFF_FFFF;
    localparam logic [PHASE_WIDTH-1:0] STEP_MIN   = 32'h8000_0000;
    localparam longint                 SAMPLE_HI  = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint                 SAMPLE_LO  = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = SAMPLE_WIDTH'(SAMPLE_HI);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = SAMPLE_WIDTH'(SAMPLE_LO);
    localparam longint unsigned FULL_SCALE  = 64'd1 << (SAMPLE_WIDTH - 1);
    localparam longint unsigned PHASE_MASK  = (64'd1 << PHASE_WIDTH) - 64'd1;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // one row of the directed table: a register write or an input item
    typedef struct packed {
        logic                           is_cfg;
        logic [CFG_IDX_W-1:0]           reg_idx;
        logic [CFG_DATA_W-1:0]          reg_data;
        t_op                            op;
        logic [PHASE_WIDTH-1:0]         step;
        logic [IDX_W-1:0]               idx;
        logic [SAMPLE_WIDTH-1:0]        value;
        logic                           typed;
        logic signed [SAMPLE_WIDTH-1:0] typed_sample;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [1:0]                     i_operation;
    logic signed [PHASE_WIDTH-1:0]  i_increment;
    logic [IDX_W-1:0]               i_table_index;
    logic signed [SAMPLE_WIDTH-1:0] i_table_value;
    logic                           empty;
    logic                           pop;
    logic signed [SAMPLE_WIDTH-1:0] o_sample;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index;
    logic [CFG_DATA_W-1:0]          i_cfg_data;

    // oscillator state as the predictor sees it
    logic [PHASE_WIDTH-1:0]         osc_phase;
    logic [PHASE_WIDTH-1:0]         osc_base_step;
    logic [WAVE_W-1:0]              osc_wave;
    logic signed [SAMPLE_WIDTH-1:0] user_wave [0:TABLE_DEPTH];
    bit                             user_written [0:TABLE_DEPTH];

    logic signed [SAMPLE_WIDTH-1:0] pending_samples [$];
    t_row                           directed_rows [NUM_DIRECTED];

    bit item_burst;
    bit pop_burst;
    int fail_count;
    int items_sent;
    int table_writes;
    int reg_writes;
    int samples_checked;
    int idle_cycles;

    wavetable_oscillator_lerp uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_operation   (i_operation),
        .i_increment   (i_increment),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .empty         (empty),
        .pop           (pop),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic longint clip_sample(longint x);
        if (x > SAMPLE_HI) return SAMPLE_HI;
        if (x < SAMPLE_LO) return SAMPLE_LO;
        return x;
    endfunction

    // sine entry: quarter-wave fold, horner series to x^11 in q30
    function automatic longint sine_point(longint unsigned i);
        longint unsigned ang, r, x, x2, h, s, mag;
        int              quad;
        ang  = ((i << 32) / 64'(TABLE_DEPTH)) & 64'hFFFF_FFFF;
        quad = int'(ang >> 30);
        r    = ang & (Q30_ONE - 64'd1);
        if (quad % 2 == 1) r = Q30_ONE - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        h  = Q30_ONE;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd110;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
        s   = (x * h) >> 30;
        mag = ((s << (SAMPLE_WIDTH - 1)) + (Q30_ONE >> 1)) >> 30;
        return clip_sample(quad >= 2 ? -longint'(mag) : longint'(mag));
    endfunction

    // table entry of the selected waveform, entry n is the wrap copy
    function automatic longint wave_entry(longint unsigned i);
        longint unsigned n, j;
        longint          rr;
        n = 64'(TABLE_DEPTH);
        if (i > n) i = n;
        j = (i == n) ? 64'd0 : i;
        case (osc_wave)
            WAVE_TRIANGLE: begin
                rr = longint'((64'd2 * j * FULL_SCALE + n / 64'd2) / n);
                return clip_sample((64'd2 * j < n) ? rr : longint'(FULL_SCALE) - rr);
            end
            WAVE_SQUARE: begin
                if (i == 64'd0 || i == n) return 0;
                return (i <= n / 64'd2) ? SAMPLE_HI : SAMPLE_LO;
            end
            WAVE_SAW: begin
                return clip_sample(longint'(FULL_SCALE)
                                   - longint'((j * FULL_SCALE + n / 64'd2) / n));
            end
            WAVE_USER: begin
                return longint'(user_wave[i]);
            end
            default: begin
                return sine_point(i);
            end
        endcase
    endfunction

    // table read position scaled by the phase width, read backwards
    function automatic longint unsigned read_product();
        return ((64'd1 << PHASE_WIDTH) - 64'(osc_phase)) * 64'(TABLE_DEPTH - 1);
    endfunction

    // interpolated sample at the current phase, then step the phase
    function automatic logic signed [SAMPLE_WIDTH-1:0] advance_oscillator(
        logic [PHASE_WIDTH-1:0] step
    );
        longint unsigned prod, pos, frac;
        longint          lo, hi, mixed;
        prod = read_product();
        pos  = prod >> PHASE_WIDTH;
        frac = (prod & PHASE_MASK) >> (PHASE_WIDTH - FRAC_W);
        osc_phase = osc_phase + step;
        lo = wave_entry(pos);
        hi = wave_entry(pos + 64'd1);
        mixed = clip_sample(lo + (((hi - lo) * longint'(frac)
                                   + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W));
        return mixed[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sample_value();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        return SAMPLE_WIDTH'($urandom);
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_row item_row(t_op op, logic [PHASE_WIDTH-1:0] step,
                                      logic [IDX_W-1:0] idx, logic [SAMPLE_WIDTH-1:0] value);
        t_row r;
        r = '0;
        r.op    = op;
        r.step  = step;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic t_row checked_row(t_op op, logic [PHASE_WIDTH-1:0] step,
                                         logic signed [SAMPLE_WIDTH-1:0] want);
        t_row r;
        r = item_row(op, step, '0, '0);
        r.typed        = 1'b1;
        r.typed_sample = want;
        return r;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // hand one item over the push side and record what it should produce
    task automatic push_item(t_op op, logic [PHASE_WIDTH-1:0] step, logic [IDX_W-1:0] idx,
                             logic [SAMPLE_WIDTH-1:0] value, logic typed,
                             logic signed [SAMPLE_WIDTH-1:0] typed_sample);
        int                             gap;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        gap = item_burst ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          = 1'b1;
        i_operation   = op;
        i_increment   = step;
        i_table_index = idx;
        i_table_value = value;
        do @(posedge i_clk); while (full);
        items_sent++;
        case (op)
            OP_TICK_BASE, OP_TICK_STEP: begin
                smp = advance_oscillator(op == OP_TICK_BASE ? osc_base_step : step);
                pending_samples.push_back(typed ? typed_sample : smp);
            end
            OP_WRITE: begin
                table_writes++;
                if (idx <= IDX_W'(TABLE_DEPTH)) begin
                    user_wave[idx]    = value;
                    user_written[idx] = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // a tick on the user table first fills any entry it would read unwritten
    task automatic send_item(t_op op, logic [PHASE_WIDTH-1:0] step, logic [IDX_W-1:0] idx,
                             logic [SAMPLE_WIDTH-1:0] value, logic typed,
                             logic signed [SAMPLE_WIDTH-1:0] typed_sample);
        longint unsigned pos;
        int              k;
        if (osc_wave == WAVE_USER && (op == OP_TICK_BASE || op == OP_TICK_STEP)) begin
            pos = read_product() >> PHASE_WIDTH;
            for (k = 0; k < 2; k++) begin
                if (!user_written[pos + k])
                    push_item(OP_WRITE, $urandom, IDX_W'(pos + k), sample_value(), 1'b0, '0);
            end
        end
        push_item(op, step, idx, value, typed, typed_sample);
    endtask

    // stop pushing and let every sample and any table write drain
    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_WAVEFORM: osc_wave      = data[WAVE_W-1:0];
            CFG_BASE_INC: osc_base_step = data[PHASE_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // result side: random pop stalls, each sample checked on accept
    initial begin
        int                             wait_cycles;
        logic signed [SAMPLE_WIDTH-1:0] want;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            wait_cycles = pop_burst ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0) begin
                pop = 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_samples.size() == 0) begin
                note_failure($sformatf("sample %0d arrived with none outstanding", o_sample));
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (o_sample !== want)
                    note_failure($sformatf("sample expected %0d, got %0d", want, o_sample));
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            idle_cycles = 0;
        end else if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles, %0d samples outstanding",
                         idle_cycles, pending_samples.size());
                $display("tb_wavetable_oscillator_lerp failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int                     ph, k, pick;
        t_op                    op;
        logic [PHASE_WIDTH-1:0] step;
        logic [IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]  data;

        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_operation   = OP_TICK_BASE;
        i_increment   = '0;
        i_table_index = '0;
        i_table_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_WAVEFORM;
        i_cfg_data    = '0;
        osc_phase     = '0;
        osc_base_step = '0;
        osc_wave      = WAVE_SINE;
        foreach (user_written[i]) user_written[i] = 1'b0;

        directed_rows = '{
            // sine after reset, then the widest steps back to zero phase
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            item_row(OP_TICK_STEP, STEP_MAX, 11'h7FF, 16'hFFFF),
            item_row(OP_TICK_STEP, STEP_MIN, 11'h000, 16'h8000),
            item_row(OP_TICK_STEP, 32'd1, 11'h400, 16'h7FFF),
            item_row(OP_TICK_STEP, 32'hFFFF_FFFF, 11'h3FF, 16'h0001),
            item_row(OP_TICK_STEP, 32'd1, 11'h555, 16'h5555),
            // square at zero phase hits the last entry, half a turn the middle pair
            cfg_row(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE)),
            checked_row(OP_TICK_BASE, 32'd0, SAMPLE_MIN),
            checked_row(OP_TICK_STEP, STEP_MIN, SAMPLE_MIN),
            checked_row(OP_TICK_BASE, 32'd0, SAMPLE_MAX),
            // unused operation gives nothing
            item_row(OP_NONE, 32'hA5A5_5A5A, 11'h2AA, 16'hA5A5),
            cfg_row(CFG_WAVEFORM, CFG_DATA_W'(WAVE_TRIANGLE)),
            item_row(OP_TICK_STEP, 32'h4000_0000, 11'h000, 16'h0000),
            item_row(OP_TICK_STEP, 32'hC000_0001, 11'h000, 16'h0000),
            cfg_row(CFG_BASE_INC, STEP_MIN),
            cfg_row(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW)),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            // unused waveform code with junk above it plays sine
            cfg_row(CFG_BASE_INC, STEP_MAX),
            cfg_row(CFG_WAVEFORM, {29'h1FFF_FFFF, WAVE_SPARE_5}),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            // writes to unknown registers change nothing
            cfg_row(CFG_SPARE_2, 32'hFFFF_FFFF),
            cfg_row(CFG_SPARE_3, 32'h0000_0000),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            // one past the wrap copy and the top index are dropped
            item_row(OP_WRITE, 32'd0, 11'd1025, 16'h7FFF),
            item_row(OP_WRITE, 32'd0, 11'h7FF, 16'h8000),
            item_row(OP_WRITE, 32'd0, 11'd0, 16'h8000),
            item_row(OP_WRITE, 32'd0, 11'd1024, 16'h7FFF),
            item_row(OP_WRITE, 32'd0, 11'd1023, 16'h8000),
            cfg_row(CFG_WAVEFORM, CFG_DATA_W'(WAVE_USER)),
            cfg_row(CFG_BASE_INC, 32'h0100_0000),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000),
            item_row(OP_TICK_BASE, 32'd0, 11'h000, 16'h0000)
        };

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            else
                send_item(directed_rows[r].op, directed_rows[r].step, directed_rows[r].idx,
                          directed_rows[r].value, directed_rows[r].typed,
                          directed_rows[r].typed_sample);
        end

        // random phases, each with its own waveform and base step
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            data = $urandom;
            data[WAVE_W-1:0] = (ph < 8) ? WAVE_W'(ph) : WAVE_W'($urandom_range(0, 7));
            write_reg(CFG_WAVEFORM, data);
            case (ph % 5)
                0: data = STEP_MIN;
                1: data = STEP_MAX;
                2: data = '0;
                3: data = $urandom_range(0, 32'h0040_0000);
                default: data = $urandom;
            endcase
            write_reg(CFG_BASE_INC, data);
            write_reg((ph % 2 == 1) ? CFG_SPARE_3 : CFG_SPARE_2, $urandom);
            item_burst = (ph % 3 == 1);
            pop_burst  = (ph % 4 == 1) || (ph % 4 == 3);

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      op = OP_TICK_BASE;
                else if (pick < 80) op = OP_TICK_STEP;
                else if (pick < 95) op = OP_WRITE;
                else                op = OP_NONE;
                // mostly small musical steps, some anywhere in range
                if ($urandom_range(0, 3) == 0) begin
                    step = $urandom;
                end else begin
                    step = $urandom_range(0, 32'h0400_0000);
                    if ($urandom_range(0, 1) == 1) step = -step;
                end
                if (op != OP_WRITE)
                    idx = IDX_W'($urandom);
                else if ($urandom_range(0, 7) == 0)
                    idx = IDX_W'($urandom_range(TABLE_DEPTH + 1, (1 << IDX_W) - 1));
                else
                    idx = IDX_W'($urandom_range(0, TABLE_DEPTH));
                send_item(op, step, idx, sample_value(), 1'b0, '0);
            end
        end
        item_burst = 1'b0;
        pop_burst  = 1'b0;

        // drain and report
        wait_idle();
        $display("covered %0d items (%0d table writes), %0d directed rows, %0d random phases",
                 items_sent, table_writes, NUM_DIRECTED, RANDOM_PHASES);
        $display("%0d samples checked, %0d register writes, %0d mismatches",
                 samples_checked, reg_writes, fail_count);
        if (fail_count == 0) begin
            $display("tb_wavetable_oscillator_lerp passed");
        end else begin
            $display("tb_wavetable_oscillator_lerp failed");
        end
        $finish;
    end

endmodule
